[rtl/utf8pv_pkg.sv]
// shared types, constants and helpers for the utf-8 prefix validator
package utf8pv_pkg;

    localparam longint unsigned MAX_BYTES = 64'd65536;
    localparam int CNT_W = 17;
    localparam int VAL_W = 21;

    // counters stop at the size bound or at the top of their field
    localparam logic [CNT_W-1:0] CNT_CAP =
        CNT_W'((MAX_BYTES < 64'h1FFFF) ? MAX_BYTES : 64'h1FFFF);

    localparam logic [VAL_W-1:0] MIN_TWO    = 21'h000080;
    localparam logic [VAL_W-1:0] MIN_THREE  = 21'h000800;
    localparam logic [VAL_W-1:0] MIN_FOUR   = 21'h010000;
    localparam logic [VAL_W-1:0] MAX_CP     = 21'h10FFFF;
    localparam logic [VAL_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [VAL_W-1:0] SURR_HI    = 21'h00DFFF;

    localparam logic [2:0] SEQ_TWO   = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR  = 3'd4;

    // per-string decoder state
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] bytes;
        logic [CNT_W-1:0] limit;
        logic [1:0]       pending;
        logic [2:0]       seq_len;
        logic [VAL_W-1:0] partial;
        logic             error;
        logic             first;
    } state_t;

    // one result transaction
    typedef struct packed {
        logic [CNT_W-1:0] codepoint_count;
        logic [CNT_W-1:0] prefix_bytes;
        logic             malformed;
    } result_t;

    // saturating counter add
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [2:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W - 2){1'b0}}, b};
        return (s > {1'b0, CNT_CAP}) ? CNT_CAP : s[CNT_W-1:0];
    endfunction

endpackage

[rtl/utf8pv_step.sv]
// combinational decode of one byte against the current string state
module utf8pv_step (
    input  utf8pv_pkg::state_t                 cur,
    input  logic [7:0]                         data_byte,
    input  logic                               final_byte,
    input  logic                               is_empty,
    input  logic [utf8pv_pkg::CNT_W-1:0]       codepoint_limit,
    output utf8pv_pkg::state_t                 nxt,
    output utf8pv_pkg::result_t                res,
    output logic                               produce
);

    utf8pv_pkg::state_t            work;
    logic [utf8pv_pkg::VAL_W-1:0]  pv;
    logic [utf8pv_pkg::VAL_W-1:0]  minimum;

    // cleared string state with first-of-string mark kept as given
    function automatic utf8pv_pkg::state_t cleared(input utf8pv_pkg::state_t s);
        utf8pv_pkg::state_t c;
        c         = s;
        c.count   = '0;
        c.bytes   = '0;
        c.pending = '0;
        c.seq_len = '0;
        c.partial = '0;
        c.error   = 1'b0;
        return c;
    endfunction

    // next state and result for one transaction
    always_comb
    begin
        work    = cur;
        res     = '0;
        produce = 1'b0;
        pv      = {cur.partial[utf8pv_pkg::VAL_W-7:0], data_byte[5:0]};
        minimum = utf8pv_pkg::MIN_FOUR;

        if (is_empty)
        begin
            work       = cleared(cur);
            work.first = 1'b1;
            produce    = 1'b1;
        end
        else
        begin
            // new string: clear and latch the limit
            if (cur.first)
            begin
                work       = cleared(cur);
                work.limit = codepoint_limit;
                work.first = 1'b0;
            end

            pv = {work.partial[utf8pv_pkg::VAL_W-7:0], data_byte[5:0]};
            if (work.seq_len == utf8pv_pkg::SEQ_TWO)
                minimum = utf8pv_pkg::MIN_TWO;
            else if (work.seq_len == utf8pv_pkg::SEQ_THREE)
                minimum = utf8pv_pkg::MIN_THREE;
            else
                minimum = utf8pv_pkg::MIN_FOUR;

            if (!work.error)
            begin
                if (work.pending == 2'd0)
                begin
                    // lead byte, only while under the limit
                    if (work.count < work.limit)
                    begin
                        if (!data_byte[7])
                        begin
                            work.count = utf8pv_pkg::sat_add(work.count, 3'd1);
                            work.bytes = utf8pv_pkg::sat_add(work.bytes, 3'd1);
                        end
                        else if (data_byte[7:5] == 3'b110)
                        begin
                            work.seq_len = utf8pv_pkg::SEQ_TWO;
                            work.partial = {16'b0, data_byte[4:0]};
                            work.pending = 2'd1;
                        end
                        else if (data_byte[7:4] == 4'b1110)
                        begin
                            work.seq_len = utf8pv_pkg::SEQ_THREE;
                            work.partial = {17'b0, data_byte[3:0]};
                            work.pending = 2'd2;
                        end
                        else if (data_byte[7:3] == 5'b11110)
                        begin
                            work.seq_len = utf8pv_pkg::SEQ_FOUR;
                            work.partial = {18'b0, data_byte[2:0]};
                            work.pending = 2'd3;
                        end
                        else
                        begin
                            work.error = 1'b1;
                        end
                    end
                end
                else if (data_byte[7:6] != 2'b10)
                begin
                    // bad continuation byte
                    work.error   = 1'b1;
                    work.pending = 2'd0;
                end
                else
                begin
                    work.partial = pv;
                    work.pending = work.pending - 2'd1;
                    // sequence complete: range, overlong and surrogate checks
                    if (work.pending == 2'd0)
                    begin
                        if (pv < minimum || pv > utf8pv_pkg::MAX_CP ||
                            (pv >= utf8pv_pkg::SURR_LO && pv <= utf8pv_pkg::SURR_HI))
                        begin
                            work.error = 1'b1;
                        end
                        else
                        begin
                            work.count = utf8pv_pkg::sat_add(work.count, 3'd1);
                            work.bytes = utf8pv_pkg::sat_add(work.bytes, work.seq_len);
                        end
                    end
                end
            end

            // end of string: cut-off check and report
            if (final_byte)
            begin
                if (work.pending != 2'd0 && !work.error)
                    work.error = 1'b1;
                res.codepoint_count = work.count;
                res.prefix_bytes    = work.bytes;
                res.malformed       = work.error;
                produce             = 1'b1;
                work                = cleared(work);
                work.first          = 1'b1;
            end
        end

        nxt = work;
    end

endmodule

[rtl/utf8_prefix_validator.sv]
// top level of the utf-8 prefix validator with state and output buffering
//
// Input channel: one byte of a string per transaction (data_byte,
// final_byte, is_empty, codepoint_limit), qualified by in_valid and
// held off by in_stall. The limit is taken from the first byte of each
// string. Output channel: one result transaction (codepoint_count,
// prefix_bytes, malformed) for each byte marked final_byte and for each
// is_empty transaction, qualified by out_valid and held by out_stall.
// Throughput: one byte per cycle while in_stall is low; the decode of a
// byte is a single pass through the step logic into the string state
// registers. A result is registered in the output register, or in the
// skid register while the output register is held by out_stall.
// Reset clears all string state and marks the next byte as the first of a
// string; both output slots empty.
// When the receiver stalls, the result waits in the output register and a
// second result goes to a skid register; in_stall rises only while the
// skid register is full, so bytes keep flowing while one result waits.
module utf8_prefix_validator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      data_byte,
    input  logic                            final_byte,
    input  logic                            is_empty,
    input  logic [utf8pv_pkg::CNT_W-1:0]    codepoint_limit,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [utf8pv_pkg::CNT_W-1:0]    codepoint_count,
    output logic [utf8pv_pkg::CNT_W-1:0]    prefix_bytes,
    output logic                            malformed
);

    utf8pv_pkg::state_t   state_reg;
    utf8pv_pkg::state_t   state_next;
    utf8pv_pkg::result_t  step_res;
    logic                 step_produce;
    logic                 in_accept;
    logic                 res_valid;

    utf8pv_pkg::result_t  out_reg;
    logic                 out_valid_reg;
    utf8pv_pkg::result_t  skid_reg;
    logic                 skid_valid_reg;

    // per-byte decode
    utf8pv_step u_step (
        .cur             (state_reg),
        .data_byte       (data_byte),
        .final_byte      (final_byte),
        .is_empty        (is_empty),
        .codepoint_limit (codepoint_limit),
        .nxt             (state_next),
        .res             (step_res),
        .produce         (step_produce)
    );

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign res_valid = in_accept && step_produce;

    // string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{count: '0, bytes: '0, limit: '0, pending: '0,
                           seq_len: '0, partial: '0, error: 1'b0, first: 1'b1};
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // output register and skid register valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg  <= skid_valid_reg || res_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // result payloads
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            out_reg <= skid_valid_reg ? skid_reg : step_res;
        end
        else if (res_valid)
        begin
            skid_reg <= step_res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign codepoint_count = out_reg.codepoint_count;
    assign prefix_bytes    = out_reg.prefix_bytes;
    assign malformed       = out_reg.malformed;

    // skid register only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full with empty output register");

    // every codepoint takes at least one byte
    a_count_le_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.count <= state_reg.bytes)
        else $error("codepoint count exceeds byte count");

    // byte counter never passes the cap
    a_bytes_capped: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bytes <= utf8pv_pkg::CNT_CAP)
        else $error("byte counter above cap");

    // an open sequence never coexists with an error
    a_pending_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.pending != 2'd0) |-> !state_reg.error)
        else $error("pending continuation bytes after an error");

    // a fresh string starts with clear counters
    a_first_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.first |-> (state_reg.count == '0 && state_reg.bytes == '0))
        else $error("counters not cleared at start of string");

endmodule
